// ===== rtl/core/tlc_pkg.sv =====
`default_nettype none

package tlc_pkg;

  // Field widths
  localparam int CNT_W    = 16;
  localparam int LUX_W    = 27;
  localparam int SEG_W    = 3;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // Ratio is Q0.16; interpolation fraction keeps 15 bits; powers are Q0.24
  localparam int RATIO_W  = 16;
  localparam int FRAC_W   = 15;
  localparam int PWR_W    = 24;
  localparam int COEF_W   = 20;

  // Power table geometry: entry k stands for x = k / (2 * POW_ENTRIES)
  localparam int POW_ENTRIES = 64;
  localparam int POW_IDX_W   = $clog2(POW_ENTRIES + 1);
  localparam int T_W         = RATIO_W + POW_IDX_W;
  localparam int IDX_FULL_W  = T_W - FRAC_W;

  // Low segment datapath: A1*P, then A0*2^24 - A1*P (nonnegative part fits 43 bits)
  localparam int PROD1_W  = COEF_W + PWR_W;
  localparam int D_W      = 43;
  localparam int LO_SHIFT = 32;

  // Linear segments
  localparam int LIN_W     = COEF_W + CNT_W;
  localparam int LIN_SHIFT = 8;

  // Q0.24 coefficients
  localparam logic [COEF_W-1:0] A0 = 20'd510027;
  localparam logic [COEF_W-1:0] A1 = 20'd1040187;
  localparam logic [COEF_W-1:0] A2 = 20'd375810;
  localparam logic [COEF_W-1:0] A3 = 20'd520094;
  localparam logic [COEF_W-1:0] A4 = 20'd214748;
  localparam logic [COEF_W-1:0] A5 = 20'd256691;
  localparam logic [COEF_W-1:0] A6 = 20'd24495;
  localparam logic [COEF_W-1:0] A7 = 20'd18790;

  // Segment codes
  localparam logic [SEG_W-1:0] SEG_PWR  = 3'd0;
  localparam logic [SEG_W-1:0] SEG_LIN1 = 3'd1;
  localparam logic [SEG_W-1:0] SEG_LIN2 = 3'd2;
  localparam logic [SEG_W-1:0] SEG_LIN3 = 3'd3;
  localparam logic [SEG_W-1:0] SEG_ZERO = 3'd4;

  typedef logic [PWR_W-1:0] pow_tab_t [0:POW_ENTRIES];

  // true when p^5 * (2M)^7 <= 2^120 * k^7
  function automatic logic pow_fits(input logic [PWR_W-1:0] p, input int k);
    logic [255:0] lhs;
    logic [255:0] rhs;
    lhs = 256'(p);
    for (int i = 1; i < 5; i++) begin
      lhs = lhs * 256'(p);
    end
    rhs = 256'(1) << 120;
    for (int i = 0; i < 7; i++) begin
      lhs = lhs * 256'(2 * POW_ENTRIES);
      rhs = rhs * 256'(k);
    end
    return lhs <= rhs;
  endfunction

  // floor(2^24 * x^1.4), largest fitting value found bit by bit from the top
  function automatic pow_tab_t build_pow_tab();
    pow_tab_t tab;
    logic [PWR_W-1:0] p;
    logic [PWR_W-1:0] cand;
    for (int k = 0; k <= POW_ENTRIES; k++) begin
      p = '0;
      for (int bt = PWR_W - 1; bt >= 0; bt--) begin
        cand = p | (PWR_W'(1) << bt);
        if (pow_fits(cand, k)) begin
          p = cand;
        end
      end
      tab[k] = p;
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

`default_nettype wire

// ===== rtl/core/tlc_div.sv =====
`default_nettype none

module tlc_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tlc_pkg::CNT_W-1:0]   dividend,
  input  logic [tlc_pkg::CNT_W-1:0]   divisor,
  output logic [tlc_pkg::RATIO_W-1:0] quot
);
  import tlc_pkg::*;

  // Restoring division of dividend*2^16 by divisor, four quotient bits per stage.
  // Exact only when dividend < divisor, which holds for every low-segment item.
  localparam int STEPS  = 4;
  localparam int STAGES = RATIO_W / STEPS;

  logic [CNT_W-1:0]   rem_r [STAGES];
  logic [RATIO_W-1:0] q_r   [STAGES];
  logic [CNT_W-1:0]   dvs_r [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stg
    logic [CNT_W-1:0]   rem_in;
    logic [CNT_W-1:0]   dvs_in;
    logic [RATIO_W-1:0] q_in;
    logic [CNT_W-1:0]   rem_nxt;
    logic [RATIO_W-1:0] q_nxt;

    if (s == 0) begin : g_first
      assign rem_in = dividend;
      assign dvs_in = divisor;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem_r[s-1];
      assign dvs_in = dvs_r[s-1];
      assign q_in   = q_r[s-1];
    end

    always_comb begin
      logic [CNT_W:0] sh;
      rem_nxt = rem_in;
      q_nxt   = q_in;
      for (int j = 0; j < STEPS; j++) begin
        sh = {rem_nxt, 1'b0};
        if (sh >= {1'b0, dvs_in}) begin
          rem_nxt = CNT_W'(sh - {1'b0, dvs_in});
          q_nxt   = {q_nxt[RATIO_W-2:0], 1'b1};
        end else begin
          rem_nxt = sh[CNT_W-1:0];
          q_nxt   = {q_nxt[RATIO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        q_r[s]   <= q_nxt;
        dvs_r[s] <= dvs_in;
      end
    end
  end

  assign quot = q_r[STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/tlc_pow.sv =====
`default_nettype none

module tlc_pow (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tlc_pkg::RATIO_W-1:0] ratio,
  output logic [tlc_pkg::PWR_W-1:0]   pwr
);
  import tlc_pkg::*;

  logic [T_W-1:0]        t;
  logic [IDX_FULL_W-1:0] idx_full;
  logic [POW_IDX_W-1:0]  lo;
  logic [POW_IDX_W-1:0]  hi;
  logic [PWR_W-1:0]      a_nxt;
  logic [PWR_W-1:0]      diff_nxt;
  logic [PWR_W-1:0]      b_val;

  logic [PWR_W-1:0]      a_r;
  logic [PWR_W-1:0]      diff_r;
  logic [FRAC_W-1:0]     f_r;
  logic [PWR_W-1:0]      pwr_r;

  logic [PWR_W+FRAC_W-1:0] step;

  assign t        = T_W'(ratio) * T_W'(POW_ENTRIES);
  assign idx_full = t[T_W-1:FRAC_W];
  assign lo       = idx_full[POW_IDX_W-1:0];
  assign hi       = lo + POW_IDX_W'(1);

  always_comb begin
    b_val = '0;
    if (idx_full >= IDX_FULL_W'(POW_ENTRIES)) begin
      a_nxt    = POW_TAB[POW_ENTRIES];
      diff_nxt = '0;
    end else begin
      a_nxt = POW_TAB[lo];
      b_val = POW_TAB[hi];
      diff_nxt = (b_val < a_nxt) ? '0 : b_val - a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a_nxt;
      diff_r <= diff_nxt;
      f_r    <= t[FRAC_W-1:0];
    end
  end

  assign step = (PWR_W+FRAC_W)'(diff_r) * (PWR_W+FRAC_W)'(f_r);

  always_ff @(posedge clk) begin
    if (en) begin
      pwr_r <= a_r + step[PWR_W+FRAC_W-1:FRAC_W];
    end
  end

  assign pwr = pwr_r;

endmodule

`default_nettype wire

// ===== rtl/core/tlc_seg0.sv =====
`default_nettype none

module tlc_seg0 (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tlc_pkg::PWR_W-1:0] pwr,
  input  logic [tlc_pkg::CNT_W-1:0] bb,    // broadband count, aligned with d_r for the final multiply
  output logic [tlc_pkg::LUX_W-1:0] lux
);
  import tlc_pkg::*;

  logic [PROD1_W-1:0]     a1p_r;
  logic [PROD1_W:0]       full;
  logic [D_W-1:0]         d_r;
  logic [CNT_W+D_W-1:0]   prod;
  logic [LUX_W-1:0]       lux_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a1p_r <= PROD1_W'(A1) * PROD1_W'(pwr);
    end
  end

  // B*A0*2^24 - B*A1*P = B*(A0*2^24 - A1*P); clamp the bracket at zero
  assign full = {1'b0, A0, {PWR_W{1'b0}}} - {1'b0, a1p_r};

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= full[PROD1_W] ? '0 : full[D_W-1:0];
    end
  end

  assign prod = (CNT_W+D_W)'(bb) * (CNT_W+D_W)'(d_r);

  always_ff @(posedge clk) begin
    if (en) begin
      lux_r <= prod[CNT_W+D_W-1:LO_SHIFT];
    end
  end

  assign lux = lux_r;

endmodule

`default_nettype wire

// ===== rtl/core/tlc_lin.sv =====
`default_nettype none

module tlc_lin (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tlc_pkg::CNT_W-1:0] bb,
  input  logic [tlc_pkg::CNT_W-1:0] ir,
  input  logic [tlc_pkg::SEG_W-1:0] seg,
  output logic [tlc_pkg::LUX_W-1:0] lux
);
  import tlc_pkg::*;

  logic [COEF_W-1:0] ca;
  logic [COEF_W-1:0] cb;
  logic [LIN_W-1:0]  pa_r;
  logic [LIN_W-1:0]  pb_r;
  logic [LIN_W-1:0]  diff;
  logic [LUX_W-1:0]  lux_r;

  always_comb begin
    case (seg)
      SEG_LIN1: begin
        ca = A2;
        cb = A3;
      end
      SEG_LIN2: begin
        ca = A4;
        cb = A5;
      end
      SEG_LIN3: begin
        ca = A6;
        cb = A7;
      end
      default: begin
        ca = '0;
        cb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= LIN_W'(ca) * LIN_W'(bb);
      pb_r <= LIN_W'(cb) * LIN_W'(ir);
    end
  end

  assign diff = (pa_r > pb_r) ? pa_r - pb_r : '0;

  // products stay below 2^35, so the shifted value fits the lux field
  always_ff @(posedge clk) begin
    if (en) begin
      lux_r <= diff[LUX_W+LIN_SHIFT-1:LIN_SHIFT];
    end
  end

  assign lux = lux_r;

endmodule

`default_nettype wire

// ===== rtl/core/two_channel_lux_calculator.sv =====
`default_nettype none

// Lux from a broadband/infrared count pair. Each transfer on the in_ side carries one
// pair; each transfer on the out_ side returns lux as unsigned Q11.16 (truncated) and
// the formula segment picked by the infrared/broadband ratio (4 = forced zero for a
// ratio above 1.3 or a zero broadband count). One pair is taken every clock cycle
// while in_tready is high. The datapath has ten stages (segment select, four divider
// stages for the Q0.16 ratio, two power-table stages, three low-segment multiply
// stages), the first of which loads on the input transfer edge; the output register
// follows them. A two-entry output buffer keeps in_tready high while one result
// waits; in_tready drops only when both entries are full.
module two_channel_lux_calculator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tlc_pkg::IN_DATA_W-1:0]    in_tdata,   // [15:0] broadband_count, [31:16] infrared_count
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tlc_pkg::OUT_DATA_W-1:0]   out_tdata,  // [26:0] lux_value, [31:27] zero
  output logic [tlc_pkg::SEG_W-1:0]        out_tuser   // [2:0] segment_used
);
  import tlc_pkg::*;

  localparam int DEPTH   = 10;
  localparam int LAST    = DEPTH - 1;
  localparam int B_TAP   = LAST - 1;
  localparam int LIN_DLY = DEPTH - 3;

  typedef struct packed {
    logic [CNT_W-1:0] b;
    logic [SEG_W-1:0] seg;
  } side_t;

  logic             en;
  logic [DEPTH-1:0] vld_r;
  side_t            side_r [DEPTH];
  logic [CNT_W-1:0] ir1_r;

  logic [CNT_W-1:0] in_b;
  logic [CNT_W-1:0] in_i;
  logic [SEG_W-1:0] seg_nxt;
  logic [23:0]      i100;

  logic [RATIO_W-1:0] ratio;
  logic [PWR_W-1:0]   pwr;
  logic [LUX_W-1:0]   lux_lo;
  logic [LUX_W-1:0]   lux_lin;
  logic [LUX_W-1:0]   lin_dly_r [LIN_DLY];

  logic [LUX_W-1:0]   fin_lux;
  logic [SEG_W-1:0]   fin_seg;

  logic               out_valid_r;
  logic [LUX_W-1:0]   out_lux_r;
  logic [SEG_W-1:0]   out_seg_r;
  logic               skid_valid_r;
  logic [LUX_W-1:0]   skid_lux_r;
  logic [SEG_W-1:0]   skid_seg_r;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  assign in_b = in_tdata[CNT_W-1:0];
  assign in_i = in_tdata[2*CNT_W-1:CNT_W];
  assign i100 = 24'(in_i) * 24'd100;

  // boundaries compared exactly as 100*I against 50B, 61B, 80B, 130B
  always_comb begin
    if (in_b == '0) begin
      seg_nxt = SEG_ZERO;
    end else if (i100 <= 24'(in_b) * 24'd50) begin
      seg_nxt = SEG_PWR;
    end else if (i100 <= 24'(in_b) * 24'd61) begin
      seg_nxt = SEG_LIN1;
    end else if (i100 <= 24'(in_b) * 24'd80) begin
      seg_nxt = SEG_LIN2;
    end else if (i100 <= 24'(in_b) * 24'd130) begin
      seg_nxt = SEG_LIN3;
    end else begin
      seg_nxt = SEG_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= '{b: in_b, seg: seg_nxt};
      ir1_r     <= in_i;
      for (int k = 1; k < DEPTH; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  tlc_div u_div (
    .clk      (clk),
    .en       (en),
    .dividend (ir1_r),
    .divisor  (side_r[0].b),
    .quot     (ratio)
  );

  tlc_pow u_pow (
    .clk   (clk),
    .en    (en),
    .ratio (ratio),
    .pwr   (pwr)
  );

  tlc_seg0 u_seg0 (
    .clk (clk),
    .en  (en),
    .pwr (pwr),
    .bb  (side_r[B_TAP].b),
    .lux (lux_lo)
  );

  tlc_lin u_lin (
    .clk (clk),
    .en  (en),
    .bb  (side_r[0].b),
    .ir  (ir1_r),
    .seg (side_r[0].seg),
    .lux (lux_lin)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      lin_dly_r[0] <= lux_lin;
      for (int k = 1; k < LIN_DLY; k++) begin
        lin_dly_r[k] <= lin_dly_r[k-1];
      end
    end
  end

  assign fin_seg = side_r[LAST].seg;

  always_comb begin
    case (fin_seg)
      SEG_PWR:  fin_lux = lux_lo;
      SEG_LIN1: fin_lux = lin_dly_r[LIN_DLY-1];
      SEG_LIN2: fin_lux = lin_dly_r[LIN_DLY-1];
      SEG_LIN3: fin_lux = lin_dly_r[LIN_DLY-1];
      default:  fin_lux = '0;
    endcase
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= vld_r[LAST];
      end
    end else if (en && vld_r[LAST]) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_lux_r <= skid_lux_r;
        out_seg_r <= skid_seg_r;
      end else begin
        out_lux_r <= fin_lux;
        out_seg_r <= fin_seg;
      end
    end else if (en) begin
      skid_lux_r <= fin_lux;
      skid_seg_r <= fin_seg;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_lux_r);
  assign out_tuser  = out_seg_r;

endmodule

`default_nettype wire
